// ===== rtl/hls_pkg.sv =====
// Shared types, link state codes and constants for the heartbeat link supervisor.
// No dependencies; every rtl module imports this package.
`default_nettype none

package hls_pkg;

    // Link state codes as they travel on the item and result fields
    localparam logic [2:0] LINK_CODE_IDLE    = 3'd0;
    localparam logic [2:0] LINK_CODE_ON      = 3'd1;
    localparam logic [2:0] LINK_CODE_WAITING = 3'd2;
    localparam logic [2:0] LINK_CODE_ERROR   = 3'd3;
    localparam logic [2:0] LINK_CODE_UP      = 3'd4;

    // Configuration register indexes
    localparam logic CFG_HEARTBEAT_PERIOD = 1'b0;
    localparam logic CFG_VALUE_PERIOD     = 1'b1;

    localparam int unsigned PERIOD_W = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd6000;

    localparam logic [7:0] WAIT_LIMIT  = 8'd250;
    localparam logic [7:0] SLOW_TOGGLE = 8'd200;
    localparam logic [7:0] FAST_TOGGLE = 8'd50;

    // LED modes
    localparam logic [1:0] BLINK_HOLD = 2'd0;
    localparam logic [1:0] BLINK_SLOW = 2'd1;
    localparam logic [1:0] BLINK_FAST = 2'd2;

    typedef enum logic [4:0] {
        LINK_IDLE    = 5'b00001,
        LINK_ON      = 5'b00010,
        LINK_WAITING = 5'b00100,
        LINK_ERROR   = 5'b01000,
        LINK_UP      = 5'b10000
    } link_fsm_t;

    typedef struct packed {
        logic       link_write;
        logic [2:0] link_state_in;
        logic       heartbeat_sent;
        logic       value_sent;
        logic [1:0] blink_mode;
    } in_item_t;

    typedef struct packed {
        logic       heartbeat_request;
        logic       value_request;
        logic [2:0] link_state_out;
        logic       fault_mark;
        logic       led_level;
    } out_item_t;

    // Post-tick status of the link unit
    typedef struct packed {
        logic       heartbeat_request;
        logic [2:0] link_state_out;
        logic       fault_mark;
    } link_status_t;

    function automatic link_fsm_t link_decode(input logic [2:0] code);
        link_fsm_t s;
        case (code)
            LINK_CODE_ON:      s = LINK_ON;
            LINK_CODE_WAITING: s = LINK_WAITING;
            LINK_CODE_ERROR:   s = LINK_ERROR;
            LINK_CODE_UP:      s = LINK_UP;
            default:           s = LINK_IDLE;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] link_encode(input link_fsm_t s);
        logic [2:0] code;
        case (s)
            LINK_ON:      code = LINK_CODE_ON;
            LINK_WAITING: code = LINK_CODE_WAITING;
            LINK_ERROR:   code = LINK_CODE_ERROR;
            LINK_UP:      code = LINK_CODE_UP;
            default:      code = LINK_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hls_link_unit.sv =====
// Link state machine with heartbeat and wait timeout counters.
// Depends on hls_pkg.
`default_nettype none

module hls_link_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire hls_pkg::in_item_t    item,
    input  wire logic [15:0]          heartbeat_period,
    output hls_pkg::link_status_t     status
);
    import hls_pkg::*;

    link_fsm_t   link_reg, link_next, link_w;
    logic [15:0] heart_count_reg, heart_count_next, heart_inc;
    logic [7:0]  wait_count_reg, wait_count_next, wait_inc;
    logic        fault_reg, fault_next;
    logic        pending_reg, pending_next;

    always_comb
    begin
        // apply software writes first
        link_w = link_reg;
        if (item.link_write && (item.link_state_in inside {[LINK_CODE_IDLE:LINK_CODE_UP]}))
        begin
            link_w = link_decode(item.link_state_in);
        end
        pending_next     = pending_reg & ~item.heartbeat_sent;
        link_next        = link_w;
        heart_count_next = heart_count_reg;
        wait_count_next  = wait_count_reg;
        fault_next       = fault_reg;
        heart_inc        = heart_count_reg + 16'd1;
        wait_inc         = wait_count_reg + 8'd1;

        if (link_w != LINK_IDLE)
        begin
            heart_count_next = heart_inc;
            if (heart_inc > heartbeat_period)
            begin
                pending_next     = 1'b1;
                heart_count_next = '0;
            end
            case (link_w)
                LINK_WAITING:
                begin
                    wait_count_next = wait_inc;
                    if (wait_inc > WAIT_LIMIT)
                    begin
                        wait_count_next = '0;
                        link_next       = LINK_ERROR;
                    end
                end
                LINK_ERROR:
                begin
                    fault_next = 1'b1;
                end
                LINK_ON:
                begin
                    // ON either clears a fault or starts waiting for the peer
                    wait_count_next  = '0;
                    heart_count_next = '0;
                    if (fault_reg)
                        fault_next = 1'b0;
                    else
                        link_next = LINK_WAITING;
                end
                LINK_UP:
                begin
                    link_next = LINK_WAITING;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg        <= LINK_IDLE;
            heart_count_reg <= '0;
            wait_count_reg  <= '0;
            fault_reg       <= 1'b0;
            pending_reg     <= 1'b0;
        end
        else if (advance)
        begin
            link_reg        <= link_next;
            heart_count_reg <= heart_count_next;
            wait_count_reg  <= wait_count_next;
            fault_reg       <= fault_next;
            pending_reg     <= pending_next;
        end
    end

    assign status.heartbeat_request = pending_next;
    assign status.link_state_out    = link_encode(link_next);
    assign status.fault_mark        = fault_next;

endmodule

`default_nettype wire

// ===== rtl/hls_value_unit.sv =====
// Value report period counter and value-ready flag.
// Depends on hls_pkg.
`default_nettype none

module hls_value_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire hls_pkg::in_item_t  item,
    input  wire logic [15:0]        value_period,
    output logic                    value_request
);
    import hls_pkg::*;

    logic [15:0] value_count_reg, value_count_next, value_inc;
    logic        ready_reg, ready_next, ready_w;

    always_comb
    begin
        ready_w          = ready_reg & ~item.value_sent;
        ready_next       = ready_w;
        value_count_next = value_count_reg;
        value_inc        = value_count_reg + 16'd1;
        if (!ready_w)
        begin
            value_count_next = value_inc;
            if (value_inc > value_period)
            begin
                value_count_next = '0;
                ready_next       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_count_reg <= '0;
            ready_reg       <= 1'b1;
        end
        else if (advance)
        begin
            value_count_reg <= value_count_next;
            ready_reg       <= ready_next;
        end
    end

    assign value_request = ready_next;

endmodule

`default_nettype wire

// ===== rtl/hls_led_unit.sv =====
// Status LED blinker with separate slow and fast toggle counters.
// Depends on hls_pkg.
`default_nettype none

module hls_led_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire hls_pkg::in_item_t  item,
    output logic                    led_level
);
    import hls_pkg::*;

    logic [7:0] slow_count_reg, slow_count_next, slow_inc;
    logic [7:0] fast_count_reg, fast_count_next, fast_inc;
    logic       led_reg, led_next;

    always_comb
    begin
        slow_count_next = slow_count_reg;
        fast_count_next = fast_count_reg;
        led_next        = led_reg;
        slow_inc        = slow_count_reg + 8'd1;
        fast_inc        = fast_count_reg + 8'd1;
        case (item.blink_mode)
            BLINK_SLOW:
            begin
                slow_count_next = slow_inc;
                if (slow_inc == SLOW_TOGGLE)
                begin
                    slow_count_next = '0;
                    led_next        = ~led_reg;
                end
            end
            BLINK_FAST:
            begin
                fast_count_next = fast_inc;
                if (fast_inc == FAST_TOGGLE)
                begin
                    fast_count_next = '0;
                    led_next        = ~led_reg;
                end
            end
            default:
            begin
                // hold the level; unused mode acts as hold
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_count_reg <= '0;
            fast_count_reg <= '0;
            led_reg        <= 1'b0;
        end
        else if (advance)
        begin
            slow_count_reg <= slow_count_next;
            fast_count_reg <= fast_count_next;
            led_reg        <= led_next;
        end
    end

    assign led_level = led_next;

endmodule

`default_nettype wire

// ===== rtl/heartbeat_link_supervisor_core.sv =====
// Heartbeat link supervisor: one timer tick per input item, one result per tick.
// Usage:
//   Item channel (item_valid / item_stall / item): each item is one tick and carries
//   the software writes applied before it (link state write, heartbeat and value
//   acknowledges, LED blink mode).
//   Result channel (result_valid / result_stall / result): the link state, fault
//   mark, heartbeat and value requests and LED level after that tick.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 sets the
//   heartbeat period, index 1 the value period. cfg_ready is always high; write
//   only while no tick is in flight.
// Flow: an accepted item lands in the input register, and its result is loaded into
//   the result register once that register is free (empty or not stalled). Throughput
//   is one item per cycle while result_stall stays low, set by the single combinational
//   tick update between the input register and the result register.
// Reset: all counters clear, link goes idle, value-ready is set, LED off, both
//   periods return to 6000, and both pipeline registers empty.
// Stall: while result_stall holds a waiting result, one more item is still taken
//   into the input register; item_stall rises only when both registers are full.
// Depends on hls_pkg, hls_link_unit, hls_value_unit, hls_led_unit.
`default_nettype none

module heartbeat_link_supervisor_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire hls_pkg::in_item_t   item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output hls_pkg::out_item_t       result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import hls_pkg::*;

    // Configuration registers
    logic [PERIOD_W-1:0] heartbeat_period_reg;
    logic [PERIOD_W-1:0] value_period_reg;

    // Input register stage
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;

    // Result register stage
    logic      result_valid_reg, result_valid_next;
    out_item_t result_reg;

    logic         accept;
    logic         result_free;
    logic         advance;
    link_status_t link_status;
    logic         value_request;
    logic         led_level;

    assign cfg_ready = 1'b1;

    // Take config writes whenever offered; unknown indexes cannot occur
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heartbeat_period_reg <= PERIOD_RESET;
            value_period_reg     <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEARTBEAT_PERIOD: heartbeat_period_reg <= cfg_data;
                CFG_VALUE_PERIOD:     value_period_reg     <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Advance the held item into the result register when that slot frees up
    assign result_free = ~result_valid_reg | ~result_stall;
    assign advance     = in_valid_reg & result_free;
    assign item_stall  = in_valid_reg & ~result_free;
    assign accept      = item_valid & ~item_stall;

    assign in_valid_next     = accept | (in_valid_reg & ~advance);
    assign result_valid_next = advance | (result_valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers: load only on a handshake, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= item;
        if (advance)
        begin
            result_reg.heartbeat_request <= link_status.heartbeat_request;
            result_reg.value_request     <= value_request;
            result_reg.link_state_out    <= link_status.link_state_out;
            result_reg.fault_mark        <= link_status.fault_mark;
            result_reg.led_level         <= led_level;
        end
    end

    // Tick units: each commits its state when the item advances
    hls_link_unit u_link (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .item             (in_item_reg),
        .heartbeat_period (heartbeat_period_reg),
        .status           (link_status)
    );

    hls_value_unit u_value (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .item          (in_item_reg),
        .value_period  (value_period_reg),
        .value_request (value_request)
    );

    hls_led_unit u_led (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (in_item_reg),
        .led_level (led_level)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
